/* design/lbq_pkg.sv */
`default_nettype none
package lbq_pkg;

  localparam int KEY_COUNT_DEF = 128;
  localparam int KEY_W         = 32;
  localparam int SLOPE_W       = 33;
  localparam int ME_W          = 7;
  localparam int POS_W         = 7;
  localparam int SEG_W         = 8;
  localparam int CMD_W         = 2;
  localparam int STAT_W        = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_LOADED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_BUILT     = 3'd1;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd4;
  localparam logic [STAT_W-1:0] ST_REFUSED   = 3'd5;

endpackage
`default_nettype wire

/* design/lbq_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle, result rounded toward +inf.
module lbq_div #(
  parameter int NW = 43
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic signed [NW-1:0]           num,
  input  wire logic signed [lbq_pkg::SLOPE_W-1:0] den,
  output logic                                done,
  output logic signed [NW:0]                  quo
);
  import lbq_pkg::*;

  localparam int CNT_W = $clog2(NW + 1);
  localparam int RW    = SLOPE_W + 1;

  logic [RW-1:0]      rem_r;
  logic [NW-1:0]      quo_r;
  logic [SLOPE_W-1:0] dm_r;
  logic               neg_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               run_r;
  logic               done_r;

  logic [NW-1:0]      nmag;
  logic [SLOPE_W-1:0] dmag;
  logic [RW-1:0]      sh;
  logic [RW-1:0]      diff;
  logic               ge;
  logic [NW:0]        qmag;

  always_comb begin
    nmag = num[NW-1] ? NW'(-num) : NW'(num);
    dmag = den[SLOPE_W-1] ? SLOPE_W'(-den) : SLOPE_W'(den);
    sh   = {rem_r[RW-2:0], quo_r[NW-1]};
    ge   = (sh >= {1'b0, dm_r});
    diff = sh - {1'b0, dm_r};
    qmag = {1'b0, quo_r};
    if (neg_r) begin
      quo = -$signed(qmag);
    end else begin
      quo = $signed(qmag + (NW+1)'(rem_r != '0));
    end
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NW - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= nmag;
      dm_r  <= dmag;
      neg_r <= num[NW-1] ^ den[SLOPE_W-1];
    end else if (run_r) begin
      rem_r <= ge ? diff : sh;
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

/* design/learned_index_build_and_query_unit.sv */
`default_nettype none
// Piecewise linear learned index over KEY_COUNT keys.
// Input channel (in_valid/in_stall, in_command, in_key): load the next key
// (keys in ascending order), build the segments, or query a key. Result
// channel (out_valid/out_stall) returns one status/position/segment per item.
// cfg_we/cfg_wdata set max_error; write it only while the block is idle.
// One item at a time: in_stall stays high from the transfer until the result
// sits in the output register. A query checks the key domain, searches the
// segment maximum keys, predicts a position (one pass of the shared divider
// with an NW = $clog2(KEY_COUNT)+36 bit dividend when the slope is nonzero) and
// searches the clamped window. A build walks every key checked through that
// divider when the slope is nonzero; the key that ends a segment is checked
// again by the next one. The divider sets the pace.
// Reset clears the key count, the built flag, the last segment and
// max_error; the key and segment memories hold garbage until written.
// A stalled result holds in the output register; the sequencer finishes
// the next item and waits in its final state until the register frees up.
// Build refuses until all keys are loaded, queries refuse until a build.
module learned_index_build_and_query_unit #(
  parameter int KEY_COUNT = lbq_pkg::KEY_COUNT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [lbq_pkg::CMD_W-1:0]      in_command,
  input  wire logic signed [lbq_pkg::KEY_W-1:0] in_key,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [lbq_pkg::STAT_W-1:0]          out_status,
  output logic [lbq_pkg::POS_W-1:0]           out_position,
  output logic [lbq_pkg::SEG_W-1:0]           out_segment,
  input  wire logic                           cfg_we,
  input  wire logic [lbq_pkg::ME_W-1:0]       cfg_wdata
);
  import lbq_pkg::*;

  localparam int IW = $clog2(KEY_COUNT);
  localparam int CW = IW + 1;
  localparam int AW = IW + SLOPE_W + 2;   // segment offset width
  localparam int NW = AW + 1;             // dividend width
  localparam int PW = NW + 1;             // prediction width
  localparam logic [IW-1:0] LAST = IW'(KEY_COUNT - 1);
  localparam logic [CW-1:0] FULL = CW'(KEY_COUNT);

  typedef struct packed {
    logic signed [KEY_W-1:0]   maxk;
    logic signed [AW-1:0]      off;
    logic signed [SLOPE_W-1:0] slope;
  } seg_ent_t;

  typedef enum logic [25:0] {
    S_IDLE = 26'd1 << 0,  S_DONE = 26'd1 << 1,  S_BANC = 26'd1 << 2,
    S_BAN1 = 26'd1 << 3,  S_BAN2 = 26'd1 << 4,  S_BMUL = 26'd1 << 5,
    S_BOFF = 26'd1 << 6,  S_BCRD = 26'd1 << 7,  S_BCKY = 26'd1 << 8,
    S_BPS  = 26'd1 << 9,  S_BPW  = 26'd1 << 10, S_BCHK = 26'd1 << 11,
    S_BMRD = 26'd1 << 12, S_BMWR = 26'd1 << 13, S_QD0  = 26'd1 << 14,
    S_QD1  = 26'd1 << 15, S_QD2  = 26'd1 << 16, S_QSL  = 26'd1 << 17,
    S_QSC  = 26'd1 << 18, S_QSF  = 26'd1 << 19, S_QPR  = 26'd1 << 20,
    S_QPS  = 26'd1 << 21, S_QPW  = 26'd1 << 22, S_QWN  = 26'd1 << 23,
    S_QKL  = 26'd1 << 24, S_QKC  = 26'd1 << 25
  } state_t;

  // control registers
  state_t            state_r, state_nxt;
  logic [ME_W-1:0]   max_err_r;
  logic [CW-1:0]     loaded_cnt_r, loaded_cnt_nxt;
  logic              built_r, built_nxt;
  logic [IW-1:0]     last_seg_r, last_seg_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath registers
  logic [IW-1:0]             i_r, i_nxt;
  logic [IW-1:0]             j_r, j_nxt;
  logic [CW-1:0]             x_r, x_nxt;
  logic signed [KEY_W-1:0]   k0_r, k0_nxt;
  logic signed [AW-1:0]      a_r, a_nxt;
  logic signed [SLOPE_W-1:0] b_r, b_nxt;
  logic signed [AW-1:0]      mul_r, mul_nxt;
  logic signed [KEY_W-1:0]   pkey_r, pkey_nxt;
  logic signed [PW-1:0]      pred_r, pred_nxt;
  logic [CW-1:0]             lo_r, lo_nxt, hi_r, hi_nxt, seg_r, seg_nxt;
  logic [IW-1:0]             mid_r, mid_nxt;
  logic                      lt_r, lt_nxt;
  logic signed [KEY_W-1:0]   key_r, key_nxt;
  logic [STAT_W-1:0]         res_status_r, res_status_nxt;
  logic [IW-1:0]             res_pos_r, res_pos_nxt;
  logic [CW-1:0]             res_seg_r, res_seg_nxt;
  logic [STAT_W-1:0]         out_status_r, out_status_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;
  logic [SEG_W-1:0]          out_seg_r, out_seg_nxt;

  // memories
  logic signed [KEY_W-1:0] key_mem [KEY_COUNT];
  seg_ent_t                seg_mem [KEY_COUNT];
  logic signed [KEY_W-1:0] key_q_r;
  seg_ent_t                seg_q_r;
  logic [IW-1:0]           kaddr, saddr;
  logic                    k_wr, s_wr;
  seg_ent_t                s_wdata;

  // shared divider
  logic                    div_start, div_done;
  logic signed [NW-1:0]    div_num;
  logic signed [PW-1:0]    div_quo;

  // scratch
  logic                    accept;
  logic signed [AW-1:0]    mul_full;
  logic [IW-1:0]           jstart;
  logic signed [PW:0]      err, me_s, wlo, whi, wlo_c, whi_c;
  logic [CW:0]             msum;
  logic [CW-1:0]           last_ext, seg_c;
  logic [IW+POS_W-1:0]     pos_ext;
  logic [CW+SEG_W-1:0]     seg_ext;
  logic                    seg_last;

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;
  assign out_segment  = out_seg_r;

  assign div_num  = {{(NW-KEY_W){pkey_r[KEY_W-1]}}, pkey_r} + {a_r[AW-1], a_r};
  assign mul_full = AW'(b_r * $signed({1'b0, i_r}));
  assign jstart   = (x_r == '0) ? IW'(2) : i_r;
  assign last_ext = {1'b0, last_seg_r};
  assign msum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign me_s     = $signed({{(PW+1-ME_W){1'b0}}, max_err_r});
  assign err      = {pred_r[PW-1], pred_r} - $signed({{(PW+1-IW){1'b0}}, j_r});
  assign wlo      = {pred_r[PW-1], pred_r} - me_s;
  assign whi      = {pred_r[PW-1], pred_r} + me_s;
  assign wlo_c    = (wlo < 0) ? '0 : wlo;
  assign whi_c    = (whi > $signed({{(PW+1-IW){1'b0}}, LAST}))
                    ? $signed({{(PW+1-IW){1'b0}}, LAST}) : whi;
  assign seg_c    = (seg_r > last_ext) ? last_ext : seg_r;
  assign seg_last = (x_r != '0) && (i_r == LAST);
  assign pos_ext  = (IW+POS_W)'(res_pos_r);
  assign seg_ext  = (CW+SEG_W)'(res_seg_r);

  lbq_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (b_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt      = state_r;
    loaded_cnt_nxt = loaded_cnt_r;
    built_nxt      = built_r;
    last_seg_nxt   = last_seg_r;
    out_valid_nxt  = out_valid_r;
    i_nxt = i_r;  j_nxt = j_r;  x_nxt = x_r;
    k0_nxt = k0_r;  a_nxt = a_r;  b_nxt = b_r;  mul_nxt = mul_r;
    pkey_nxt = pkey_r;  pred_nxt = pred_r;
    lo_nxt = lo_r;  hi_nxt = hi_r;  seg_nxt = seg_r;  mid_nxt = mid_r;
    lt_nxt = lt_r;  key_nxt = key_r;
    res_status_nxt = res_status_r;  res_pos_nxt = res_pos_r;
    res_seg_nxt = res_seg_r;
    out_status_nxt = out_status_r;  out_pos_nxt = out_pos_r;
    out_seg_nxt = out_seg_r;
    kaddr = '0;  saddr = '0;  k_wr = 1'b0;  s_wr = 1'b0;
    s_wdata = '{maxk: key_q_r, off: a_r, slope: b_r};
    div_start = 1'b0;

    // drop the result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt        = in_key;
          res_status_nxt = ST_REFUSED;
          res_pos_nxt    = '0;
          res_seg_nxt    = '0;
          state_nxt      = S_DONE;
          case (in_command)
            CMD_LOAD: begin
              if (loaded_cnt_r < FULL) begin
                k_wr           = 1'b1;
                loaded_cnt_nxt = loaded_cnt_r + CW'(1);
                res_status_nxt = ST_LOADED;
              end
            end
            CMD_BUILD: begin
              if (loaded_cnt_r == FULL) begin
                i_nxt     = '0;
                x_nxt     = '0;
                state_nxt = S_BANC;
              end
            end
            CMD_QUERY: begin
              if (built_r) begin
                state_nxt = S_QD0;
              end
            end
            default: ;
          endcase
        end
      end

      // ---- build: anchor the segment at key i ----
      S_BANC: begin
        if (i_r == LAST) begin
          a_nxt     = AW'(i_r) - AW'(1);
          b_nxt     = '0;
          j_nxt     = jstart;
          state_nxt = S_BCRD;
        end else begin
          kaddr     = i_r;
          state_nxt = S_BAN1;
        end
      end
      S_BAN1: begin
        k0_nxt    = key_q_r;
        kaddr     = i_r + IW'(1);
        state_nxt = S_BAN2;
      end
      S_BAN2: begin
        if (key_q_r == k0_r) begin
          a_nxt     = AW'(i_r);
          b_nxt     = '0;
          j_nxt     = jstart;
          state_nxt = S_BCRD;
        end else begin
          b_nxt     = SLOPE_W'(key_q_r) - SLOPE_W'(k0_r);
          state_nxt = S_BMUL;
        end
      end
      S_BMUL: begin
        mul_nxt   = mul_full;
        state_nxt = S_BOFF;
      end
      S_BOFF: begin
        // offset = slope*i - k[i]
        a_nxt     = mul_r - AW'(k0_r);
        j_nxt     = jstart;
        state_nxt = S_BCRD;
      end

      // ---- build: extend while the prediction error stays in bound ----
      S_BCRD: begin
        kaddr     = j_r;
        state_nxt = S_BCKY;
      end
      S_BCKY: begin
        pkey_nxt  = key_q_r;
        state_nxt = S_BPS;
      end
      S_BPS: begin
        if (b_r == '0) begin
          pred_nxt  = PW'(a_r);
          state_nxt = S_BCHK;
        end else begin
          div_start = 1'b1;
          state_nxt = S_BPW;
        end
      end
      S_BPW: begin
        if (div_done) begin
          pred_nxt  = div_quo;
          state_nxt = S_BCHK;
        end
      end
      S_BCHK: begin
        if (err > me_s || err < -me_s) begin
          i_nxt     = j_r;
          state_nxt = S_BMRD;
        end else if (j_r == LAST) begin
          i_nxt     = LAST;
          state_nxt = S_BMRD;
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_BCRD;
        end
      end

      // ---- build: record the segment ----
      S_BMRD: begin
        kaddr     = seg_last ? LAST : i_r - IW'(1);
        state_nxt = S_BMWR;
      end
      S_BMWR: begin
        s_wr = 1'b1;
        if (seg_last || (x_r + CW'(1) == FULL)) begin
          last_seg_nxt   = seg_last ? x_r[IW-1:0] : LAST;
          built_nxt      = 1'b1;
          res_status_nxt = ST_BUILT;
          res_seg_nxt    = {1'b0, last_seg_nxt};
          state_nxt      = S_DONE;
        end else begin
          x_nxt     = x_r + CW'(1);
          state_nxt = S_BANC;
        end
      end

      // ---- query: key domain ----
      S_QD0: begin
        kaddr     = '0;
        state_nxt = S_QD1;
      end
      S_QD1: begin
        lt_nxt    = (key_r < key_q_r);
        kaddr     = LAST;
        state_nxt = S_QD2;
      end
      S_QD2: begin
        if (lt_r || key_r > key_q_r) begin
          res_status_nxt = ST_OUTSIDE;
          state_nxt      = S_DONE;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = last_ext + CW'(1);
          state_nxt = S_QSL;
        end
      end

      // ---- query: search the segment maximum keys ----
      S_QSL: begin
        if (lo_r < hi_r) begin
          mid_nxt   = msum[IW:1];
          saddr     = msum[IW:1];
          state_nxt = S_QSC;
        end else begin
          seg_nxt   = hi_r;
          state_nxt = S_QSF;
        end
      end
      S_QSC: begin
        if (key_r < seg_q_r.maxk) begin
          hi_nxt    = {1'b0, mid_r};
          state_nxt = S_QSL;
        end else if (key_r > seg_q_r.maxk) begin
          lo_nxt    = {1'b0, mid_r} + CW'(1);
          state_nxt = S_QSL;
        end else begin
          seg_nxt   = {1'b0, mid_r};
          state_nxt = S_QSF;
        end
      end
      S_QSF: begin
        seg_nxt     = seg_c;
        res_seg_nxt = seg_c;
        saddr       = seg_c[IW-1:0];
        state_nxt   = S_QPR;
      end
      S_QPR: begin
        a_nxt     = seg_q_r.off;
        b_nxt     = seg_q_r.slope;
        pkey_nxt  = key_r;
        state_nxt = S_QPS;
      end
      S_QPS: begin
        if (b_r == '0) begin
          pred_nxt  = PW'(a_r);
          state_nxt = S_QWN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_QPW;
        end
      end
      S_QPW: begin
        if (div_done) begin
          pred_nxt  = div_quo;
          state_nxt = S_QWN;
        end
      end

      // ---- query: search the clamped window ----
      S_QWN: begin
        res_status_nxt = ST_NOT_FOUND;
        if (wlo_c > whi_c) begin
          state_nxt = S_DONE;
        end else begin
          lo_nxt    = wlo_c[CW-1:0];
          hi_nxt    = whi_c[CW-1:0] + CW'(1);
          state_nxt = S_QKL;
        end
      end
      S_QKL: begin
        if (lo_r < hi_r) begin
          mid_nxt   = msum[IW:1];
          kaddr     = msum[IW:1];
          state_nxt = S_QKC;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_QKC: begin
        if (key_r < key_q_r) begin
          hi_nxt    = {1'b0, mid_r};
          state_nxt = S_QKL;
        end else if (key_r > key_q_r) begin
          lo_nxt    = {1'b0, mid_r} + CW'(1);
          state_nxt = S_QKL;
        end else begin
          res_status_nxt = ST_FOUND;
          res_pos_nxt    = mid_r;
          state_nxt      = S_DONE;
        end
      end

      // hold the result until the output register is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = pos_ext[POS_W-1:0];
          out_seg_nxt    = seg_ext[SEG_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      max_err_r    <= '0;
      loaded_cnt_r <= '0;
      built_r      <= 1'b0;
      last_seg_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      loaded_cnt_r <= loaded_cnt_nxt;
      built_r      <= built_nxt;
      last_seg_r   <= last_seg_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        max_err_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;  j_r <= j_nxt;  x_r <= x_nxt;
    k0_r <= k0_nxt;  a_r <= a_nxt;  b_r <= b_nxt;  mul_r <= mul_nxt;
    pkey_r <= pkey_nxt;  pred_r <= pred_nxt;
    lo_r <= lo_nxt;  hi_r <= hi_nxt;  seg_r <= seg_nxt;  mid_r <= mid_nxt;
    lt_r <= lt_nxt;  key_r <= key_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_seg_r    <= res_seg_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_seg_r    <= out_seg_nxt;
  end

  always_ff @(posedge clk) begin
    if (k_wr) begin
      key_mem[loaded_cnt_r[IW-1:0]] <= in_key;
    end
    key_q_r <= key_mem[kaddr];
  end

  always_ff @(posedge clk) begin
    if (s_wr) begin
      seg_mem[x_r[IW-1:0]] <= s_wdata;
    end
    seg_q_r <= seg_mem[saddr];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_cnt_r <= FULL)
    else $error("key count past capacity");

  a_built_full: assert property (@(posedge clk) disable iff (!rst_n)
    built_r |-> (loaded_cnt_r == FULL))
    else $error("segments built without a full key store");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final state");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == S_BPS || state_r == S_QPS))
    else $error("divider started outside a predict step");

endmodule
`default_nettype wire

/* tb/learned_index_build_and_query_unit_tb.sv */
`timescale 1ns / 1ps
module learned_index_build_and_query_unit_tb;
  import lbq_pkg::*;

  localparam int  NKEYS      = KEY_COUNT_DEF;
  localparam int  CYCLE_CAP  = 2000000;
  localparam int  SETTLE     = 60;
  localparam int  IDLE_PCT   = 13;
  localparam int  HOLD_LEN   = 400;
  localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [SEG_W-1:0]  segment;
  } answer_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command;
  logic signed [KEY_W-1:0]  in_key;
  logic                     out_valid;
  logic                     out_stall;
  logic [STAT_W-1:0]        out_status;
  logic [POS_W-1:0]         out_position;
  logic [SEG_W-1:0]         out_segment;
  logic                     cfg_we;
  logic [ME_W-1:0]          cfg_wdata;

  learned_index_build_and_query_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_position (out_position),
    .out_segment  (out_segment),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Pending requests waiting to be offered, and answers still owed by the block.
  request_t pending_q[$];
  answer_t  owed_q[$];

  bit idle_on = 1'b1;
  int hold_kicks = 0;
  int mismatches = 0;
  int cycles = 0;

  // Shadow of the index: keys, fitted segments, configuration.
  longint keys_m[NKEYS];
  longint seg_top[NKEYS];
  longint seg_a[NKEYS];
  longint seg_b[NKEYS];
  int     seg_last;
  int     n_loaded;
  bit     is_built;
  int     err_bound;

  // Key set planned for loading.
  longint plan[NKEYS];

  // ceil((key + a) / b) in exact integer math; constant a when b is zero.
  function automatic longint fit_predict(longint key, longint a, longint b);
    longint n, q, r;
    if (b == 0) return a;
    n = key + a;
    q = n / b;
    r = n % b;
    if (r != 0 && ((r < 0) == (b < 0))) q++;
    return q;
  endfunction

  function automatic void fit_anchor(longint i, output longint a, output longint b);
    if (i >= NKEYS - 1) begin
      a = i - 1;
      b = 0;
    end else if (keys_m[i] == keys_m[i+1]) begin
      a = i;
      b = 0;
    end else begin
      a = keys_m[i+1] * i - keys_m[i] * (i + 1);
      b = keys_m[i+1] - keys_m[i];
    end
  endfunction

  // First index from i whose prediction misses by more than the bound.
  function automatic longint first_miss(longint a, longint b, longint i);
    longint e;
    for (; i < NKEYS; i++) begin
      e = fit_predict(keys_m[i], a, b) - i;
      if (e < 0) e = -e;
      if (e > err_bound) return i;
    end
    return NKEYS - 1;
  endfunction

  function automatic void fit_segments();
    longint a, b, i;
    int x;
    x = 1;
    fit_anchor(0, a, b);
    i = first_miss(a, b, 2);
    seg_top[0] = keys_m[i-1];
    seg_a[0] = a;
    seg_b[0] = b;
    while (x < NKEYS) begin
      fit_anchor(i, a, b);
      i = first_miss(a, b, i);
      seg_a[x] = a;
      seg_b[x] = b;
      if (i == NKEYS - 1) begin
        seg_top[x] = keys_m[i];
        break;
      end
      seg_top[x] = keys_m[i-1];
      x++;
    end
    if (x >= NKEYS) x = NKEYS - 1;
    seg_last = x;
    is_built = 1'b1;
  endfunction

  function automatic answer_t lookup(longint key);
    answer_t r;
    longint lo, hi, mid, seg, p, wlo, whi;
    r = '{status: ST_OUTSIDE, position: '0, segment: '0};
    if (key < keys_m[0] || key > keys_m[NKEYS-1]) return r;
    lo = 0;
    hi = seg_last + 1;
    seg = -1;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key < seg_top[mid]) hi = mid;
      else if (key > seg_top[mid]) lo = mid + 1;
      else begin
        seg = mid;
        break;
      end
    end
    if (seg < 0) seg = hi;
    if (seg > seg_last) seg = seg_last;
    r.segment = seg[SEG_W-1:0];
    p = fit_predict(key, seg_a[seg], seg_b[seg]);
    wlo = p - err_bound;
    if (wlo < 0) wlo = 0;
    whi = p + err_bound;
    if (whi > NKEYS - 1) whi = NKEYS - 1;
    lo = wlo;
    hi = whi + 1;
    r.status = ST_NOT_FOUND;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (key < keys_m[mid]) hi = mid;
      else if (key > keys_m[mid]) lo = mid + 1;
      else begin
        r.status = ST_FOUND;
        r.position = mid[POS_W-1:0];
        return r;
      end
    end
    return r;
  endfunction

  // Advance the shadow by one accepted request and return the owed answer.
  function automatic answer_t index_step(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] key);
    answer_t r;
    r = '{status: ST_REFUSED, position: '0, segment: '0};
    case (cmd)
      CMD_LOAD: begin
        if (n_loaded < NKEYS) begin
          keys_m[n_loaded] = longint'(key);
          n_loaded++;
          r.status = ST_LOADED;
        end
      end
      CMD_BUILD: begin
        if (n_loaded == NKEYS) begin
          fit_segments();
          r.status = ST_BUILT;
          r.segment = seg_last[SEG_W-1:0];
        end
      end
      CMD_QUERY: begin
        if (is_built) r = lookup(longint'(key));
      end
      default: ;
    endcase
    return r;
  endfunction

  // Input driver: record the transfer, then offer the next request or go idle.
  always @(posedge clk) begin
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid) owed_q.push_back(index_step(in_command, in_key));
      if (pending_q.size() > 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
        in_valid   <= 1'b1;
        in_command <= pending_q[0].cmd;
        in_key     <= pending_q[0].key;
        void'(pending_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: random stalls, plus a long hold-off each time one is kicked.
  initial begin
    int served;
    served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_kicks != served) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLD_LEN - 1) @(posedge clk);
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Compare each result transfer with the oldest owed answer.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d position %0d segment %0d",
                   out_status, out_position, out_segment);
      end else begin
        want = owed_q.pop_front();
        if (out_status !== want.status || out_position !== want.position ||
            out_segment !== want.segment) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected st %0d pos %0d seg %0d, got st %0d pos %0d seg %0d",
                     $realtime, want.status, want.position, want.segment,
                     out_status, out_position, out_segment);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("learned_index_build_and_query_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] key);
    pending_q.push_back('{cmd: cmd, key: key});
  endtask

  // Hold until every request is out and every answer is back, then let the block settle.
  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid || owed_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_bound(int value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[ME_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    err_bound = value;
  endtask

  // Ascending keys with a linear run, a run of equal keys, one out-of-order pair,
  // and the top key at the largest value.
  task automatic plan_keys();
    longint v, lim;
    longint t;
    v = -64'sd2147483648 + 1000;
    for (int i = 0; i < NKEYS; i++) begin
      plan[i] = v;
      if (i < 40) v += 1000;
      else if (i < 50) v += 0;
      else if (i < 90) v += $urandom_range(1, 1 << 24);
      else begin
        lim = (64'sd2147483647 - v) / (NKEYS - i);
        if (lim < 1) lim = 1;
        v += $urandom_range(1, int'(lim));
      end
    end
    t = plan[70];
    plan[70] = plan[71];
    plan[71] = t;
    plan[NKEYS-1] = 64'sd2147483647;
  endtask

  task automatic test_early_refusals();
    send_item(CMD_QUERY, 32'sd5);
    send_item(CMD_BUILD, '0);
    send_item(CMD_BAD, 32'h8000_0000);
  endtask

  task automatic test_load_keys();
    for (int i = 0; i < NKEYS; i++) begin
      send_item(CMD_LOAD, plan[i][KEY_W-1:0]);
      if (i == NKEYS / 2) send_item(CMD_BUILD, '0);
    end
    send_item(CMD_LOAD, 32'h7fff_ffff);
  endtask

  task automatic test_build_and_edges();
    send_item(CMD_BUILD, 32'hffff_ffff);
    send_item(CMD_QUERY, 32'h8000_0000);
    send_item(CMD_QUERY, 32'h7fff_ffff);
    send_item(CMD_QUERY, plan[0][KEY_W-1:0]);
    send_item(CMD_QUERY, plan[0][KEY_W-1:0] - 1);
    send_item(CMD_QUERY, plan[45][KEY_W-1:0]);
    send_item(CMD_QUERY, plan[70][KEY_W-1:0]);
    send_item(CMD_QUERY, plan[20][KEY_W-1:0] + 1);
    send_item(CMD_QUERY, '0);
    send_item(CMD_BAD, '0);
  endtask

  // Mostly well-formed lookups on stored keys and their neighbors, some raw keys and noise.
  task automatic test_random_queries(int count, bit with_build);
    int pick, idx;
    logic signed [KEY_W-1:0] k;
    if (with_build) send_item(CMD_BUILD, $urandom());
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      idx = $urandom_range(NKEYS - 1);
      k = plan[idx][KEY_W-1:0];
      if (pick < 50) send_item(CMD_QUERY, k);
      else if (pick < 70) send_item(CMD_QUERY, ($urandom_range(1)) ? k + 1 : k - 1);
      else if (pick < 92) send_item(CMD_QUERY, $urandom());
      else if (pick < 96) send_item(CMD_LOAD, $urandom());
      else send_item(CMD_BAD, $urandom());
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_kicks++;
    test_random_queries(30, 1'b0);
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_LOAD;
    in_key     <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    n_loaded   = 0;
    is_built   = 1'b0;
    seg_last   = 0;
    err_bound  = 0;
    plan_keys();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_early_refusals();
    test_load_keys();
    test_build_and_edges();
    test_random_queries(90, 1'b0);

    write_bound(127);
    test_build_and_edges();
    test_random_queries(90, 1'b0);

    write_bound(0);
    idle_on = 1'b0;
    test_random_queries(90, 1'b1);
    wait_idle();
    idle_on = 1'b1;

    write_bound($urandom_range(1, 8));
    test_random_queries(90, 1'b1);
    test_backpressure();

    write_bound($urandom_range(9, 126));
    test_random_queries(90, 1'b1);

    write_bound($urandom_range(0, 127));
    test_random_queries(60, 1'b1);

    wait_idle();
    if (mismatches == 0) begin
      $display("learned_index_build_and_query_unit_tb: PASS");
    end else begin
      $display("learned_index_build_and_query_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
